FILE: hdl/dmpt_pkg.sv
package dmpt_pkg;

   localparam int ENTRIES_DEF = 16384;

   localparam int TYPE_W  = 2;
   localparam int PID_W   = 17;
   localparam int PAGE_W  = 20;
   localparam int FRAME_W = 14;
   localparam int BADDR_W = 16;
   localparam int BYTE_W  = 8;
   localparam int ENTRY_W = 32;

   localparam int VALID_POS = 31;
   localparam int PID_LSB   = 14;

   localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FILL   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RAW_RD = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RAW_WR = 2'd3;

   typedef logic [ENTRY_W-1:0] entry_type;

endpackage

FILE: hdl/dmpt_index.sv
module dmpt_index import dmpt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  logic [PAGE_W-1:0] page_num,
   output logic [IDX_W-1:0]  idx
);

   // page mod ENTRIES by reciprocal multiply, exact for every page_num value
   localparam int SH      = PAGE_W + $clog2(ENTRIES);
   localparam int RECIP_W = PAGE_W + 2;
   localparam int PROD_W  = SH + PAGE_W;
   localparam logic [63:0] RECIP64 =
      ((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP64);
   localparam logic [PAGE_W-1:0]  DIVISOR = PAGE_W'(ENTRIES);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PAGE_W-1:0] page_d_ff, page_d_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PAGE_W-1:0] quot;
   logic [PAGE_W-1:0] rem;

   assign prod_in   = PROD_W'(page_num) * PROD_W'(RECIP);
   assign page_d_in = page_num;

   assign quot   = prod_ff[SH +: PAGE_W];
   assign rem    = page_d_ff - PAGE_W'(quot * DIVISOR);
   assign idx_in = IDX_W'(rem);

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      page_d_ff <= page_d_in;
      idx_ff    <= idx_in;
   end

   assign idx = idx_ff;

endmodule

FILE: hdl/dmpt_store.sv
module dmpt_store import dmpt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   output logic             busy
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   entry_type mem_ff [ENTRIES];
   entry_type rd_data_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic             port_we;
   logic [IDX_W-1:0] port_addr;
   entry_type        port_data;

   // clearing pass owns the write port until every entry is zero
   assign port_we   = clr_busy_ff | wr_en;
   assign port_addr = clr_busy_ff ? clr_idx_ff : wr_addr;
   assign port_data = clr_busy_ff ? '0 : wr_data;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         mem_ff[port_addr] <= port_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

FILE: hdl/direct_mapped_pid_tlb_unit.sv
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------------
// req     | req_valid/req_ready  | req_type req_pid req_page_num req_frame_in
//         |                      | req_byte_addr req_byte_data
// rsp     | rsp_valid/rsp_ready  | rsp_hit rsp_frame_out rsp_read_byte
//
// items are handled one at a time: accept, index reduction (reciprocal multiply,
// then remainder), a memory read, then decode and write back; no new item is
// taken before write-back. the result shows in the cycle after the write-back
// cycle and sits in an output register, so the next item can be taken while it waits.
// after reset a clearing pass zeroes the store, one entry a cycle;
// req_ready stays low until it ends. a stalled result holds the write-back cycle.
module direct_mapped_pid_tlb_unit import dmpt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [PID_W-1:0]   req_pid,
   input  logic [PAGE_W-1:0]  req_page_num,
   input  logic [FRAME_W-1:0] req_frame_in,
   input  logic [BADDR_W-1:0] req_byte_addr,
   input  logic [BYTE_W-1:0]  req_byte_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [FRAME_W-1:0] rsp_frame_out,
   output logic [BYTE_W-1:0]  rsp_read_byte
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIM_W = BADDR_W + 3;
   localparam logic [LIM_W-1:0] RAW_LIMIT = LIM_W'(ENTRIES * 4);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_IDX1 = 3'd1;
   localparam logic [2:0] ST_IDX2 = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_EXEC = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [TYPE_W-1:0]  type_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [BADDR_W-1:0] baddr_ff;
   logic [BYTE_W-1:0]  bdata_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;

   logic             clr_busy;
   logic             req_fire;
   logic [IDX_W-1:0] tlb_idx;
   logic             is_raw;
   logic             raw_ok;
   logic [IDX_W-1:0] raw_word;
   logic [IDX_W-1:0] mem_addr;
   logic             mem_rd;
   logic             mem_wr;
   entry_type        mem_wdata;
   entry_type        entry;
   logic [BYTE_W-1:0] lane;
   entry_type        merged;
   logic             rsp_load;
   logic             hit;

   assign req_ready = (state_ff == ST_IDLE) && !clr_busy;
   assign req_fire  = req_valid && req_ready;

   dmpt_index #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_index (
      .clock    (clock),
      .page_num (page_ff),
      .idx      (tlb_idx)
   );

   assign is_raw   = (type_ff == REQ_RAW_RD) || (type_ff == REQ_RAW_WR);
   assign raw_ok   = {3'b000, baddr_ff} < RAW_LIMIT;
   assign raw_word = raw_ok ? IDX_W'(baddr_ff[BADDR_W-1:2]) : '0;
   assign mem_addr = is_raw ? raw_word : tlb_idx;
   assign mem_rd   = (state_ff == ST_READ);

   dmpt_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (entry),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .busy    (clr_busy)
   );

   // byte 0 of a word is its most significant byte
   always_comb begin
      lane   = '0;
      merged = entry;
      case (baddr_ff[1:0])
         2'd0: begin
            lane          = entry[31:24];
            merged[31:24] = bdata_ff;
         end
         2'd1: begin
            lane          = entry[23:16];
            merged[23:16] = bdata_ff;
         end
         2'd2: begin
            lane          = entry[15:8];
            merged[15:8]  = bdata_ff;
         end
         2'd3: begin
            lane          = entry[7:0];
            merged[7:0]   = bdata_ff;
         end
         default: begin
            lane = '0;
         end
      endcase
   end

   assign hit = (type_ff == REQ_LOOKUP) && entry[VALID_POS]
             && (entry[PID_LSB +: PID_W] == pid_ff);

   assign rsp_load  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign mem_wr    = rsp_load && ((type_ff == REQ_FILL)
                    || ((type_ff == REQ_RAW_WR) && raw_ok));
   assign mem_wdata = (type_ff == REQ_FILL) ? {1'b1, pid_ff, frame_ff} : merged;

   assign rsp_hit_in   = hit;
   assign rsp_frame_in = hit ? entry[FRAME_W-1:0] : '0;
   assign rsp_byte_in  = ((type_ff == REQ_RAW_RD) && raw_ok) ? lane : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_IDX1;
            end
         end
         ST_IDX1: state_in = ST_IDX2;
         ST_IDX2: state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff  <= req_type;
         pid_ff   <= req_pid;
         page_ff  <= req_page_num;
         frame_ff <= req_frame_in;
         baddr_ff <= req_byte_addr;
         bdata_ff <= req_byte_data;
      end
      if (rsp_load) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_frame_ff <= rsp_frame_in;
         rsp_byte_ff  <= rsp_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_read_byte = rsp_byte_ff;

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##4 (state_ff == ST_EXEC))
      else $error("item did not reach write-back four cycles after accept");

   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> (rsp_load && !clr_busy))
      else $error("store written outside a result load");

   a_hit_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_byte_ff == '0))
      else $error("hit item carries a raw byte");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy) |-> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("item in flight during clearing pass");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import dmpt_pkg::*;

   localparam int TLB_ENTRIES  = ENTRIES_DEF;
   localparam int PAGE_SPAN    = 1 << PAGE_W;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 600;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [TYPE_W-1:0]  kind;
      logic [PID_W-1:0]   pid;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic [BADDR_W-1:0] addr;
      logic [BYTE_W-1:0]  data;
   } tlb_req_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame_out;
      logic [BYTE_W-1:0]  read_byte;
   } tlb_reply_type;

   typedef struct {
      tlb_req_type   req;
      bit            known;
      tlb_reply_type want;
   } script_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [TYPE_W-1:0]  req_type;
   logic [PID_W-1:0]   req_pid;
   logic [PAGE_W-1:0]  req_page_num;
   logic [FRAME_W-1:0] req_frame_in;
   logic [BADDR_W-1:0] req_byte_addr;
   logic [BYTE_W-1:0]  req_byte_data;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic [FRAME_W-1:0] rsp_frame_out;
   logic [BYTE_W-1:0]  rsp_read_byte;

   // shadow copy of the translation store
   entry_type      tlb_words [TLB_ENTRIES];
   tlb_reply_type  pending_replies [$];
   script_row_type script_rows [$];

   logic [PID_W-1:0] pid_pool [4];
   int               slot_pool [8];

   int  items_taken;
   int  kind_count [4];
   int  results_checked;
   int  hits_seen;
   int  error_count;
   int  cycle_count;
   bit  held_off;

   direct_mapped_pid_tlb_unit #(.ENTRIES(TLB_ENTRIES)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_pid       (req_pid),
      .req_page_num  (req_page_num),
      .req_frame_in  (req_frame_in),
      .req_byte_addr (req_byte_addr),
      .req_byte_data (req_byte_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_frame_out (rsp_frame_out),
      .rsp_read_byte (rsp_read_byte)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d items still due", cycle_count,
                  pending_replies.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // applies one item to the shadow store and returns what the block should answer
   function automatic tlb_reply_type predict_tlb_access(input tlb_req_type r);
      tlb_reply_type res;
      entry_type     word;
      int            slot;
      int            lane;
      res  = '0;
      slot = int'(r.page) % TLB_ENTRIES;
      lane = (3 - int'(r.addr[1:0])) * 8;
      case (r.kind)
         REQ_LOOKUP: begin
            word = tlb_words[slot];
            if (word[VALID_POS] && word[PID_LSB +: PID_W] == r.pid) begin
               res.hit       = 1'b1;
               res.frame_out = word[FRAME_W-1:0];
            end
         end
         REQ_FILL: begin
            tlb_words[slot] = {1'b1, r.pid, r.frame};
         end
         REQ_RAW_RD: begin
            if (int'(r.addr) < TLB_ENTRIES * 4) begin
               word          = tlb_words[int'(r.addr) >> 2];
               res.read_byte = word[lane +: BYTE_W];
            end
         end
         default: begin
            if (int'(r.addr) < TLB_ENTRIES * 4)
               tlb_words[int'(r.addr) >> 2][lane +: BYTE_W] = r.data;
         end
      endcase
      return res;
   endfunction

   task automatic add_row(input logic [TYPE_W-1:0] kind, input int pid, input int page,
                          input int frame, input int addr, input int data, input bit known,
                          input bit hit, input int frame_out, input int read_byte);
      script_row_type row;
      row.req            = '{kind, PID_W'(pid), PAGE_W'(page), FRAME_W'(frame),
                             BADDR_W'(addr), BYTE_W'(data)};
      row.known          = known;
      row.want.hit       = hit;
      row.want.frame_out = FRAME_W'(frame_out);
      row.want.read_byte = BYTE_W'(read_byte);
      script_rows.push_back(row);
   endtask

   function automatic tlb_req_type random_req();
      tlb_req_type r;
      int          pick;
      int          slot;
      r    = '0;
      pick = $urandom_range(99);
      if (pick < 45)
         r.kind = REQ_LOOKUP;
      else if (pick < 70)
         r.kind = REQ_FILL;
      else if (pick < 85)
         r.kind = REQ_RAW_RD;
      else
         r.kind = REQ_RAW_WR;
      // mostly a few hot slots and pids so lookups find what fills left behind
      slot = slot_pool[$urandom_range(7)];
      if ($urandom_range(9) < 7)
         r.pid = pid_pool[$urandom_range(3)];
      else
         r.pid = PID_W'($urandom);
      if ($urandom_range(3) != 0)
         r.page = PAGE_W'($urandom_range(PAGE_SPAN / TLB_ENTRIES - 1) * TLB_ENTRIES + slot);
      else
         r.page = PAGE_W'($urandom);
      if ($urandom_range(9) < 7)
         r.addr = BADDR_W'(slot * 4 + $urandom_range(3));
      else
         r.addr = BADDR_W'($urandom);
      r.frame = FRAME_W'($urandom);
      r.data  = BYTE_W'($urandom);
      return r;
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else if (pick < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // holds the item on the port until the block takes it
   task automatic offer_req(input tlb_req_type r);
      req_valid     <= 1'b1;
      req_type      <= r.kind;
      req_pid       <= r.pid;
      req_page_num  <= r.page;
      req_frame_in  <= r.frame;
      req_byte_addr <= r.addr;
      req_byte_data <= r.data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic commit_req(input tlb_req_type r, input bit known,
                             input tlb_reply_type want);
      tlb_reply_type got;
      got = predict_tlb_access(r);
      pending_replies.push_back(known ? want : got);
      kind_count[r.kind]++;
      items_taken++;
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("tb: mismatch at %0t: %s", $time, what);
   endtask

   initial begin : stimulus
      int          gap;
      bit          no_gaps;
      tlb_req_type r;
      req_valid     = 1'b0;
      req_type      = REQ_LOOKUP;
      req_pid       = '0;
      req_page_num  = '0;
      req_frame_in  = '0;
      req_byte_addr = '0;
      req_byte_data = '0;
      foreach (tlb_words[i]) tlb_words[i] = '0;

      pid_pool[0] = '0;
      pid_pool[1] = '1;
      pid_pool[2] = PID_W'($urandom);
      pid_pool[3] = PID_W'($urandom);
      slot_pool[0] = 0;
      slot_pool[1] = TLB_ENTRIES - 1;
      for (int i = 2; i < 8; i++) slot_pool[i] = $urandom_range(TLB_ENTRIES - 1);

      //      kind        pid      page      frame    addr     data  known hit frame byte
      add_row(REQ_LOOKUP, 'h00000, 'h00000, 'h0000, 'h0000, 'h00, 1, 0, 'h0000, 'h00);
      add_row(REQ_RAW_RD, 'h00000, 'h00000, 'h0000, 'h0000, 'h00, 1, 0, 'h0000, 'h00);
      add_row(REQ_RAW_RD, 'h1FFFF, 'hFFFFF, 'h3FFF, 'hFFFF, 'hFF, 1, 0, 'h0000, 'h00);
      add_row(REQ_FILL,   'h00000, 'h00000, 'h0000, 'h0000, 'h00, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h00000, 'h00000, 'h3FFF, 'hFFFF, 'hFF, 1, 1, 'h0000, 'h00);
      add_row(REQ_FILL,   'h1FFFF, 'hFFFFF, 'h3FFF, 'hFFFF, 'hFF, 1, 0, 'h0000, 'h00);
      // page differs but lands in the same slot: no page tag, so it hits
      add_row(REQ_LOOKUP, 'h1FFFF, 'h03FFF, 'h0000, 'h0000, 'h00, 1, 1, 'h3FFF, 'h00);
      add_row(REQ_LOOKUP, 'h1FFFE, 'hFFFFF, 'h3FFF, 'hFFFF, 'hFF, 1, 0, 'h0000, 'h00);
      add_row(REQ_RAW_RD, 'h00000, 'h00000, 'h0000, 'hFFFC, 'h00, 1, 0, 'h0000, 'hFF);
      add_row(REQ_RAW_RD, 'h00000, 'h00000, 'h0000, 'hFFFF, 'h00, 1, 0, 'h0000, 'hFF);
      add_row(REQ_RAW_WR, 'h1FFFF, 'hFFFFF, 'h3FFF, 'h0000, 'h00, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h00000, 'h00000, 'h0000, 'h0000, 'h00, 0, 0, 'h0000, 'h00);
      add_row(REQ_RAW_WR, 'h00000, 'h00000, 'h0000, 'h0000, 'h80, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h00000, 'h04000, 'h0000, 'h0000, 'h00, 0, 0, 'h0000, 'h00);
      add_row(REQ_RAW_WR, 'h00000, 'h00000, 'h0000, 'h0003, 'hA5, 1, 0, 'h0000, 'h00);
      add_row(REQ_RAW_RD, 'h00000, 'h00000, 'h0000, 'h0003, 'h00, 0, 0, 'h0000, 'h00);
      add_row(REQ_RAW_WR, 'h00000, 'h00000, 'h0000, 'hFFFF, 'h00, 1, 0, 'h0000, 'h00);
      add_row(REQ_RAW_RD, 'h00000, 'h00000, 'h0000, 'hFFFE, 'h00, 0, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h1FFFF, 'hFFFFF, 'h0000, 'h0000, 'h00, 0, 0, 'h0000, 'h00);
      add_row(REQ_FILL,   'h0AAAA, 'h00005, 'h1555, 'h5555, 'h55, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h0AAAA, 'h0C005, 'h2AAA, 'hAAAA, 'hAA, 0, 0, 'h0000, 'h00);
      // a raw byte over the top of the entry clears its valid bit
      add_row(REQ_RAW_WR, 'h00000, 'h00000, 'h0000, 'h0014, 'h7F, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h0AAAA, 'h00005, 'h0000, 'h0000, 'h00, 0, 0, 'h0000, 'h00);
      // raw pattern sets valid and the pid bit held in entry bit 24
      add_row(REQ_RAW_WR, 'h00000, 'h00000, 'h0000, 'h000C, 'h81, 1, 0, 'h0000, 'h00);
      add_row(REQ_LOOKUP, 'h00400, 'h00003, 'h0000, 'h0000, 'h00, 0, 0, 'h0000, 'h00);

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (script_rows[i]) begin
         offer_req(script_rows[i].req);
         commit_req(script_rows[i].req, script_rows[i].known, script_rows[i].want);
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = random_req();
         offer_req(r);
         commit_req(r, 1'b0, '0);
         // back-to-back stretches now and then
         no_gaps = (n % 400) < 80;
         gap     = no_gaps ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d items: %0d lookups, %0d fills, %0d raw reads, %0d raw writes",
               items_taken, kind_count[REQ_LOOKUP], kind_count[REQ_FILL],
               kind_count[REQ_RAW_RD], kind_count[REQ_RAW_WR]);
      $display("tb: %0d results checked, %0d lookup hits, one %0d-cycle output stall, %0d errors",
               results_checked, hits_seen, HOLD_CYCLES, error_count);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin : receiver
      int pick;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && items_taken >= HOLD_AFTER) begin
            // long hold-off so the pipeline backs up into the request side
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(99);
            if (pick < 52) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end else if (pick < 55) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(100, 200)) @(posedge clock);
            end else if (pick < 85) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (pick < 97) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(4, 12)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : reply_check
      tlb_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            flag_error($sformatf("unexpected item hit=%0d frame=%h byte=%h",
                                 rsp_hit, rsp_frame_out, rsp_read_byte));
         end else begin
            want = pending_replies.pop_front();
            results_checked++;
            if (rsp_hit === 1'b1)
               hits_seen++;
            if (rsp_hit !== want.hit || rsp_frame_out !== want.frame_out ||
                rsp_read_byte !== want.read_byte)
               flag_error($sformatf(
                  "item %0d expected hit=%0d frame=%h byte=%h, got hit=%0d frame=%h byte=%h",
                  results_checked, want.hit, want.frame_out, want.read_byte,
                  rsp_hit, rsp_frame_out, rsp_read_byte));
         end
      end
   end

endmodule
